@@ design/mmip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mmip_pkg;

    localparam int MAX_POINTS = 256;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VW = 42;

    localparam logic [16:0] FRAC_ONE = 17'd65536;
    localparam logic [16:0] PCT_RESET = 17'd32768;
    localparam logic signed [VW-1:0] Q24_MAX = VW'(64'sd549755813887);

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_PCT = 1'b1;

    typedef enum logic [1:0] {
        MODE_MEDIAN = 2'd0,
        MODE_MAD    = 2'd1,
        MODE_IQR    = 2'd2,
        MODE_PCT    = 2'd3
    } stat_mode_t;

    typedef enum logic {
        T_IDLE,
        T_RUN
    } top_state_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_LOAD,
        L_CAP,
        L_SCAN,
        L_DRAIN,
        L_DECIDE,
        L_FIN,
        L_MUL
    } lane_state_t;

    typedef struct packed {
        logic signed [31:0] x_sample;
        logic signed [31:0] y_sample;
        logic               last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [39:0] x_statistic;
        logic signed [39:0] y_statistic;
        logic               stat_status;
    } result_t;

    typedef struct packed {
        stat_mode_t      mode;
        logic [CW-1:0]   n;
        logic [CW-1:0]   posn;
        logic [15:0]     frac;
        logic            tail;
    } plan_t;

endpackage
`default_nettype wire

@@ design/median_mad_iqr_percentile.sv @@
// A pair is stored in the cycle it is accepted, unless MAX_POINTS pairs are already held;
// one pair per cycle while loading. A last pair with too few points gives its result beat
// in the next cycle. Otherwise each lane sweeps its sample RAM once per rank candidate, one
// read a cycle, in one pass (two passes for MAD and IQR), until both ranks are found.
// The result strobe lasts one cycle; the receiver cannot stall. busy is high while the lanes run.
// Async active-low reset clears pair count, state, result strobe, mode and percentile; RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module median_mad_iqr_percentile (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mmip_pkg::pair_t   pair,
    output mmip_pkg::result_t      result,
    output logic                   result_valid,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    import mmip_pkg::*;

    top_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    stat_mode_t mode_reg;
    logic [16:0] pct_reg;
    plan_t plan_reg, plan_next;
    result_t result_reg, result_next;
    logic valid_reg, valid_next;

    logic accept, full, few, go, x_done, y_done;
    logic [CW-1:0] cnt_eff, nm1;
    logic [16:0] p_clamp;
    logic [CW+16:0] t;
    logic signed [39:0] x_stat, y_stat;

    assign pready = 1'b1;
    assign accept = start && !busy;
    assign full = (count_reg == CW'(MAX_POINTS));
    assign cnt_eff = full ? count_reg : count_reg + CW'(1);
    assign nm1 = cnt_eff - CW'(1);
    assign p_clamp = (pct_reg > FRAC_ONE) ? FRAC_ONE : pct_reg;
    assign t = {17'b0, nm1} * {{CW{1'b0}}, p_clamp};
    assign few = (mode_reg == MODE_IQR) ? (cnt_eff < CW'(3)) : (cnt_eff < CW'(1));
    assign go = accept && pair.last_pair && !few;

    mmip_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && !full),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(pair.x_sample),
        .go     (go),
        .plan   (plan_reg),
        .done   (x_done),
        .stat   (x_stat)
    );

    mmip_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && !full),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(pair.y_sample),
        .go     (go),
        .plan   (plan_reg),
        .done   (y_done),
        .stat   (y_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        plan_next = plan_reg;
        result_next = result_reg;
        valid_next = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    count_next = pair.last_pair ? '0 : cnt_eff;
                    if (pair.last_pair)
                    begin
                        if (few)
                        begin
                            result_next = '{x_statistic: '0, y_statistic: '0, stat_status: 1'b1};
                            valid_next = 1'b1;
                        end
                        else
                        begin
                            plan_next.mode = mode_reg;
                            plan_next.n = cnt_eff;
                            plan_next.posn = t[CW+15:16];
                            plan_next.frac = t[15:0];
                            plan_next.tail = (t[CW+15:16] >= nm1);
                            state_next = T_RUN;
                        end
                    end
                end
            end
            T_RUN:
            begin
                if (x_done && y_done)
                begin
                    result_next = '{x_statistic: x_stat, y_statistic: y_stat, stat_status: 1'b0};
                    valid_next = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
            mode_reg <= MODE_MEDIAN;
            pct_reg <= PCT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MODE)
                begin
                    mode_reg <= stat_mode_t'(pwdata[1:0]);
                end
                else
                begin
                    pct_reg <= pwdata[16:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        result_reg <= result_next;
    end

    assign prdata = (paddr[2] == REG_PCT) ? {15'b0, pct_reg} : {30'b0, mode_reg};
    assign busy = (state_reg == T_RUN);
    assign result = result_reg;
    assign result_valid = valid_reg;

endmodule
`default_nettype wire

@@ design/mmip_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mmip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ design/mmip_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mmip_lane (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [mmip_pkg::AW-1:0] wr_addr,
    input  wire logic [31:0]           wr_data,
    input  wire logic                  go,
    input  wire mmip_pkg::plan_t       plan,
    output logic                       done,
    output logic signed [39:0]         stat
);
    import mmip_pkg::*;

    lane_state_t state_reg, state_next;
    logic pass_reg, pass_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] less_reg, less_next, leq_reg, leq_next;
    logic signed [VW-1:0] cand_reg, cand_next, v1_reg, v1_next, v2_reg, v2_next;
    logic signed [VW-1:0] med_reg, med_next, q1_reg, q1_next;
    logic signed [VW-1:0] res_reg, res_next;
    logic f1_reg, f1_next, f2_reg, f2_next, vld_reg, vld_next;
    logic [48:0] prod_reg, prod_next;

    logic [AW-1:0] rd_addr;
    logic [31:0] rd_data;
    logic [CW-1:0] k1, k2, h, off, base;
    logic xform, hit1, hit2;
    logic signed [VW-1:0] elem, avg, diff;
    logic signed [VW:0] sum, dev;

    mmip_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    function automatic logic signed [VW-1:0] sat_top(input logic signed [VW-1:0] v);
        sat_top = (v > Q24_MAX) ? Q24_MAX : v;
    endfunction

    always_comb
    begin
        h = plan.n >> 1;
        off = h + CW'(plan.n[0]);
        base = pass_reg ? off : '0;
        unique case (plan.mode)
            MODE_MEDIAN, MODE_MAD:
            begin
                k1 = (plan.n - CW'(1)) >> 1;
                k2 = plan.n >> 1;
            end
            MODE_IQR:
            begin
                k1 = base + ((h - CW'(1)) >> 1);
                k2 = base + (h >> 1);
            end
            MODE_PCT:
            begin
                k1 = plan.tail ? plan.n - CW'(1) : plan.posn;
                k2 = plan.tail ? plan.n - CW'(1) : plan.posn + CW'(1);
            end
            default:
            begin
                k1 = '0;
                k2 = '0;
            end
        endcase
    end

    assign xform = (plan.mode == MODE_MAD) && pass_reg;

    always_comb
    begin
        dev = {{3{rd_data[31]}}, rd_data, 8'b0} - {med_reg[VW-1], med_reg};
        if (xform)
        begin
            elem = dev[VW] ? VW'(-dev) : dev[VW-1:0];
        end
        else
        begin
            elem = {{2{rd_data[31]}}, rd_data, 8'b0};
        end
    end

    assign sum = {v1_reg[VW-1], v1_reg} + {v2_reg[VW-1], v2_reg};
    assign avg = sum[VW:1];
    assign diff = v2_reg - v1_reg;
    assign hit1 = !f1_reg && (less_reg <= k1) && (k1 < leq_reg);
    assign hit2 = !f2_reg && (less_reg <= k2) && (k2 < leq_reg);

    always_comb
    begin
        state_next = state_reg;
        pass_next = pass_reg;
        i_next = i_reg;
        j_next = j_reg;
        less_next = less_reg;
        leq_next = leq_reg;
        cand_next = cand_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;
        f1_next = f1_reg;
        f2_next = f2_reg;
        med_next = med_reg;
        q1_next = q1_reg;
        res_next = res_reg;
        prod_next = prod_reg;
        vld_next = (state_reg == L_SCAN);
        rd_addr = i_reg[AW-1:0];
        if (vld_reg)
        begin
            less_next = less_reg + CW'(elem < cand_reg);
            leq_next = leq_reg + CW'(elem <= cand_reg);
        end
        unique case (state_reg)
            L_IDLE:
            begin
                if (go)
                begin
                    pass_next = 1'b0;
                    i_next = '0;
                    f1_next = 1'b0;
                    f2_next = 1'b0;
                    state_next = L_LOAD;
                end
            end
            L_LOAD:
            begin
                state_next = L_CAP;
            end
            L_CAP:
            begin
                cand_next = elem;
                j_next = '0;
                less_next = '0;
                leq_next = '0;
                state_next = L_SCAN;
            end
            L_SCAN:
            begin
                rd_addr = j_reg[AW-1:0];
                if (j_reg == plan.n - CW'(1))
                begin
                    state_next = L_DRAIN;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            L_DRAIN:
            begin
                state_next = L_DECIDE;
            end
            L_DECIDE:
            begin
                if (hit1)
                begin
                    v1_next = cand_reg;
                    f1_next = 1'b1;
                end
                if (hit2)
                begin
                    v2_next = cand_reg;
                    f2_next = 1'b1;
                end
                if ((f1_reg || hit1) && (f2_reg || hit2))
                begin
                    state_next = L_FIN;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = L_LOAD;
                end
            end
            L_FIN:
            begin
                state_next = L_IDLE;
                unique case (plan.mode)
                    MODE_MEDIAN:
                    begin
                        res_next = avg;
                    end
                    MODE_MAD, MODE_IQR:
                    begin
                        if (!pass_reg)
                        begin
                            med_next = avg;
                            q1_next = avg;
                            pass_next = 1'b1;
                            i_next = '0;
                            f1_next = 1'b0;
                            f2_next = 1'b0;
                            state_next = L_LOAD;
                        end
                        else if (plan.mode == MODE_MAD)
                        begin
                            res_next = sat_top(avg);
                        end
                        else
                        begin
                            res_next = sat_top(avg - q1_reg);
                        end
                    end
                    MODE_PCT:
                    begin
                        prod_next = {16'b0, diff[40:8]} * {33'b0, plan.frac};
                        state_next = L_MUL;
                    end
                    default:
                    begin
                        res_next = avg;
                    end
                endcase
            end
            L_MUL:
            begin
                res_next = v1_reg + {1'b0, prod_reg[48:8]};
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            vld_reg <= 1'b0;
            pass_reg <= 1'b0;
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            pass_reg <= pass_next;
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        less_reg <= less_next;
        leq_reg <= leq_next;
        cand_reg <= cand_next;
        v1_reg <= v1_next;
        v2_reg <= v2_next;
        med_reg <= med_next;
        q1_reg <= q1_next;
        res_reg <= res_next;
        prod_reg <= prod_next;
    end

    assign done = (state_reg == L_IDLE);
    assign stat = res_reg[39:0];

endmodule
`default_nettype wire

@@ design/mmip_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mmip_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire mmip_pkg::pair_t   pair,
    input wire mmip_pkg::result_t result,
    input wire logic              result_valid
);
    import mmip_pkg::*;

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stat_status |->
            (result.x_statistic == '0) && (result.y_statistic == '0))
        else $error("status beat with nonzero statistic");

    a_no_result_mid: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !pair.last_pair |=> !result_valid)
        else $error("result beat without last pair");

    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid)
        else $error("result beat while busy");

endmodule

bind median_mad_iqr_percentile mmip_checker u_chk (.*);
`default_nettype wire
